@@ rtl/oftc_pkg.sv @@
// ----------------------------------------------------------------------------
// oftc_pkg
// Shared constants and types for the cursor slot tag store.
// ----------------------------------------------------------------------------
package oftc_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned ID_W           = 16;
  localparam int unsigned STAMP_W        = 32;
  localparam int unsigned SLOT_IDX_W     = 3;
  localparam int unsigned ENTRY_W        = ID_W + STAMP_W;

  // One slot as held in the tag memory.
  typedef struct packed {
    logic [ID_W-1:0]    tag;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

endpackage

@@ rtl/oftc_ram.sv @@
// ----------------------------------------------------------------------------
// oftc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module oftc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/oldest_first_slot_cache_tags.sv @@
// ----------------------------------------------------------------------------
// oldest_first_slot_cache_tags
// Fully associative cursor tag store with oldest-first replacement.
// ----------------------------------------------------------------------------
// Scan: a miss reads every slot before its result is loaded; a hit ends the
//   scan at the matching slot.
// Throughput: one request at a time, accepted the cycle after the result is
//   loaded; the result load waits while the output stalls. The scan reads
//   one tag RAM entry per cycle.
// Reset: all slots invalid; valid bits sit in flip-flops cleared at once.
// ----------------------------------------------------------------------------
module oldest_first_slot_cache_tags
  import oftc_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ID_W-1:0]       cursor_id_i,
  input  logic [STAMP_W-1:0]    now_ms_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o,
  output logic                  evicted_o,
  output logic [ID_W-1:0]       evicted_id_o
);

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e              state_q;

  // request held for the whole scan
  logic [ID_W-1:0]     id_q;
  logic [STAMP_W-1:0]  now_q;

  // scan bookkeeping: issue side and check side of the registered RAM read
  logic [CW-1:0]       issue_q;
  logic                chk_vld_q;
  logic [SW-1:0]       chk_idx_q;

  // scan findings
  logic                hit_found_q;
  logic [SW-1:0]       hit_idx_q;
  logic                free_found_q;
  logic [SW-1:0]       free_idx_q;
  logic                best_set_q;
  logic [SW-1:0]       best_idx_q;
  logic [STAMP_W-1:0]  best_stamp_q;
  logic [ID_W-1:0]     best_tag_q;

  logic [SLOT_COUNT-1:0] slot_valid_q;

  // result register
  logic                  out_valid_q;
  logic                  hit_q;
  logic [SLOT_IDX_W-1:0] slot_index_q;
  logic                  evicted_q;
  logic [ID_W-1:0]       evicted_id_q;

  // RAM port signals
  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  slot_entry_t         ram_wdata;
  logic [SW-1:0]       ram_raddr;
  slot_entry_t         ram_rdata;

  // combinational helpers
  logic                in_acc;
  logic                out_free;
  logic                issue_more;
  logic                chk_slot_valid;
  logic                chk_hit;
  logic                chk_last;
  logic [SW-1:0]       pick_idx;
  logic [SW+2:0]       pick_wide;
  logic [SW+2:0]       hit_wide;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign issue_more = (issue_q < CW'(SLOT_COUNT));
  assign ram_raddr  = issue_q[SW-1:0];

  assign chk_slot_valid = slot_valid_q[chk_idx_q];
  assign chk_hit        = chk_vld_q && chk_slot_valid && (ram_rdata.tag == id_q);
  assign chk_last       = (chk_idx_q == SW'(SLOT_COUNT - 1));

  // Prefer the first free slot, else the oldest valid one.
  assign pick_idx  = free_found_q ? free_idx_q : best_idx_q;
  assign pick_wide = {3'b000, pick_idx};
  assign hit_wide  = {3'b000, hit_idx_q};

  // Write back only on a miss, in the write step; the scan never reads then,
  // so no read can overlap a pending write of the same slot.
  assign ram_we          = (state_q == ST_WRITE) && out_free && !hit_found_q;
  assign ram_waddr       = pick_idx;
  assign ram_wdata.tag   = id_q;
  assign ram_wdata.stamp = now_q;

  oftc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
      chk_vld_q    <= 1'b0;
      issue_q      <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      best_set_q   <= 1'b0;
    end else begin
      // drain the result register; the write step reloads it itself
      if (out_valid_q && !out_stall_i && (state_q != ST_WRITE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            id_q         <= cursor_id_i;
            now_q        <= now_ms_i;
            issue_q      <= '0;
            chk_vld_q    <= 1'b0;
            hit_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            best_set_q   <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // advance the read side
          if (issue_more) begin
            issue_q   <= issue_q + CW'(1);
            chk_idx_q <= issue_q[SW-1:0];
            chk_vld_q <= 1'b1;
          end else begin
            chk_vld_q <= 1'b0;
          end

          // check the slot whose data just came back
          if (chk_vld_q) begin
            if (chk_hit) begin
              hit_found_q <= 1'b1;
              hit_idx_q   <= chk_idx_q;
              state_q     <= ST_WRITE;
            end else begin
              if (!chk_slot_valid && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= chk_idx_q;
              end
              // strict compare keeps the lowest index on a tie
              if (chk_slot_valid &&
                  (!best_set_q || (ram_rdata.stamp < best_stamp_q))) begin
                best_set_q   <= 1'b1;
                best_idx_q   <= chk_idx_q;
                best_stamp_q <= ram_rdata.stamp;
                best_tag_q   <= ram_rdata.tag;
              end
              if (chk_last) begin
                state_q <= ST_WRITE;
              end
            end
          end
        end

        ST_WRITE: begin
          // hold until the result register can take the answer
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (hit_found_q) begin
              hit_q        <= 1'b1;
              slot_index_q <= hit_wide[SLOT_IDX_W-1:0];
              evicted_q    <= 1'b0;
              evicted_id_q <= '0;
            end else begin
              hit_q                  <= 1'b0;
              slot_index_q           <= pick_wide[SLOT_IDX_W-1:0];
              slot_valid_q[pick_idx] <= 1'b1;
              evicted_q              <= !free_found_q;
              evicted_id_q           <= free_found_q ? '0 : best_tag_q;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign slot_index_o = slot_index_q;
  assign evicted_o    = evicted_q;
  assign evicted_id_o = evicted_id_q;

endmodule

@@ tb/sv/tb_oldest_first_slot_cache_tags.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oldest_first_slot_cache_tags
// Self-checking bench for the cursor slot tag store. A short table of
// requests fills the slots, hits, breaks ties and evicts the zero-stamped
// entry. Random requests then follow, with ids drawn mostly from a small
// pool so that hits and oldest-first evictions both occur often. Every
// result is checked against an in-bench model of the slots.
// ----------------------------------------------------------------------------
module tb_oldest_first_slot_cache_tags;
  import oftc_pkg::*;

  localparam int unsigned SLOTS         = SLOT_COUNT_DEF;
  localparam int unsigned RANDOM_REQS   = 1200;
  // Run the last stretch of random requests with no gaps and no stalls.
  localparam int unsigned CALM_TAIL     = 150;
  localparam int unsigned POOL_SIZE     = 12;
  // Extra wait after the last result, scaled from the slot count.
  localparam int unsigned SETTLE_CYCLES = 2 * (SLOTS + 3);
  // Longest handshake-free stretch of a correct run is roughly latency plus
  // one sender gap plus one receiver stall; allow far more.
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Where a table row takes its expected result from.
  localparam bit FROM_TABLE = 1'b1;
  localparam bit FROM_MODEL = 1'b0;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  evicted;
    logic [ID_W-1:0]       evicted_id;
  } slot_result_t;

  typedef struct packed {
    bit                 from_table;
    logic [ID_W-1:0]    cursor_id;
    logic [STAMP_W-1:0] now_ms;
    slot_result_t       want;
  } request_row_t;

  localparam slot_result_t NO_RESULT = '0;

  // Directed requests. Rows typed in by hand: first fill after reset, stamp
  // extremes, hits, and the first eviction (zero stamp is oldest, evicted
  // id is zero). Remaining rows lean on the slot model: eviction into a slot
  // that was just refilled, ties at equal stamps, time going backwards, a
  // hit that must not refresh its stamp.
  localparam int unsigned TABLE_ROWS = 22;
  request_row_t request_table [TABLE_ROWS] = '{
    '{FROM_TABLE, 16'h0000, 32'h0000_0000, '{1'b0, 3'd0, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'hFFFF, 32'hFFFF_FFFF, '{1'b0, 3'd1, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'h0000, 32'h0000_0007, '{1'b1, 3'd0, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'h8001, 32'd100,       '{1'b0, 3'd2, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'h4002, 32'd100,       '{1'b0, 3'd3, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'h2003, 32'd100,       '{1'b0, 3'd4, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'h1004, 32'd100,       '{1'b0, 3'd5, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'h0805, 32'd100,       '{1'b0, 3'd6, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'h0406, 32'd100,       '{1'b0, 3'd7, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'hFFFF, 32'h0000_0003, '{1'b1, 3'd1, 1'b0, 16'h0000}},
    '{FROM_TABLE, 16'hABCD, 32'd50,        '{1'b0, 3'd0, 1'b1, 16'h0000}},
    '{FROM_MODEL, 16'h0000, 32'd60,        NO_RESULT},
    '{FROM_MODEL, 16'h5A5A, 32'd100,       NO_RESULT},
    '{FROM_MODEL, 16'hA5A5, 32'd20,        NO_RESULT},
    '{FROM_MODEL, 16'h7FFF, 32'd1,         NO_RESULT},
    '{FROM_MODEL, 16'h8000, 32'd200,       NO_RESULT},
    '{FROM_MODEL, 16'h8000, 32'd0,         NO_RESULT},
    '{FROM_MODEL, 16'h1357, 32'd300,       NO_RESULT},
    '{FROM_MODEL, 16'h8001, 32'd0,         NO_RESULT},
    '{FROM_MODEL, 16'h0406, 32'd5,         NO_RESULT},
    '{FROM_MODEL, 16'h2468, 32'hFFFF_FFFF, NO_RESULT},
    '{FROM_MODEL, 16'hFFFE, 32'hFFFF_FFFF, NO_RESULT}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [ID_W-1:0]       cursor_id_i;
  logic [STAMP_W-1:0]    now_ms_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  hit_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic                  evicted_o;
  logic [ID_W-1:0]       evicted_id_o;

  // Bench copy of the slot store.
  logic               tag_live  [SLOTS] = '{default: 1'b0};
  logic [ID_W-1:0]    tag_id    [SLOTS] = '{default: '0};
  logic [STAMP_W-1:0] tag_stamp [SLOTS] = '{default: '0};

  slot_result_t pending_lookups [$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  bit           idle_enable    = 1'b1;

  oldest_first_slot_cache_tags u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cursor_id_i  (cursor_id_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .slot_index_o (slot_index_o),
    .evicted_o    (evicted_o),
    .evicted_id_o (evicted_id_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Look up one id in the bench slots and update them as the block would.
  function automatic slot_result_t predict_lookup(input logic [ID_W-1:0]    id,
                                                  input logic [STAMP_W-1:0] stamp);
    slot_result_t res;
    int           victim;
    bit           have_free;
    res       = '0;
    victim    = 0;
    have_free = 1'b0;
    // Hit: report the slot, touch nothing.
    for (int k = 0; k < SLOTS; k++) begin
      if (tag_live[k] && tag_id[k] == id) begin
        res.hit        = 1'b1;
        res.slot_index = SLOT_IDX_W'(k);
        return res;
      end
    end
    // Miss: take the lowest free slot first.
    for (int k = 0; k < SLOTS; k++) begin
      if (!tag_live[k] && !have_free) begin
        victim    = k;
        have_free = 1'b1;
      end
    end
    // All busy: evict the smallest stamp, lowest index on a tie.
    if (!have_free) begin
      for (int k = 1; k < SLOTS; k++) begin
        if (tag_stamp[k] < tag_stamp[victim]) victim = k;
      end
      res.evicted    = 1'b1;
      res.evicted_id = tag_id[victim];
    end
    tag_live[victim]  = 1'b1;
    tag_id[victim]    = id;
    tag_stamp[victim] = stamp;
    res.slot_index    = SLOT_IDX_W'(victim);
    return res;
  endfunction

  // Present one request, hold it until accepted, then queue its expected result.
  task automatic send_request(input logic [ID_W-1:0]    id,
                              input logic [STAMP_W-1:0] stamp,
                              input bit                 from_table,
                              input slot_result_t       want);
    slot_result_t predicted;
    in_valid_i  <= 1'b1;
    cursor_id_i <= id;
    now_ms_i    <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_lookup(id, stamp);
    pending_lookups.push_back(from_table ? want : predicted);
  endtask

  // Drop valid for a random burst now and then.
  task automatic maybe_idle();
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic [ID_W-1:0]    pool [POOL_SIZE];
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] clock_ms;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cursor_id_i <= '0;
    now_ms_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (request_table[r]) begin
      maybe_idle();
      send_request(request_table[r].cursor_id, request_table[r].now_ms,
                   request_table[r].from_table, request_table[r].want);
    end

    // Pool is a little larger than the slot count, so lookups both hit and
    // force oldest-first evictions; refresh one entry now and then.
    foreach (pool[p]) pool[p] = 16'($urandom);
    clock_ms = 32'd1000;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) idle_enable = ($urandom_range(0, 2) != 0);
      if (n >= RANDOM_REQS - CALM_TAIL) idle_enable = 1'b0;
      if ($urandom_range(0, 15) == 0) pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
      case ($urandom_range(0, 15))
        0:       id = 16'($urandom);
        1:       id = ($urandom_range(0, 1) != 0) ? '1 : '0;
        default: id = pool[$urandom_range(0, POOL_SIZE - 1)];
      endcase
      // Advance time slowly (equal stamps give ties); jump or hit an extreme
      // once in a while, which also sends time backwards.
      case ($urandom_range(0, 31))
        0:       clock_ms = '0;
        1:       clock_ms = '1;
        2, 3:    clock_ms = $urandom;
        default: clock_ms = clock_ms + $urandom_range(0, 40);
      endcase
      maybe_idle();
      send_request(id, clock_ms, FROM_MODEL, NO_RESULT);
    end

    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stall the result side in random bursts while idling is enabled.
  initial begin : result_backpressure
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    slot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected result hit=%0b slot=%0d evicted=%0b evicted_id=%h",
                   $time, hit_o, slot_index_o, evicted_o, evicted_id_o);
        end
      end else begin
        want = pending_lookups.pop_front();
        if (hit_o !== want.hit || slot_index_o !== want.slot_index ||
            evicted_o !== want.evicted || evicted_id_o !== want.evicted_id) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch expected hit=%0b slot=%0d evicted=%0b evicted_id=%h",
                     $time, want.hit, want.slot_index, want.evicted, want.evicted_id);
            $display("%0t:          actual   hit=%0b slot=%0d evicted=%0b evicted_id=%h",
                     $time, hit_o, slot_index_o, evicted_o, evicted_id_o);
          end
        end
      end
    end
  end

  // Count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/oftc_pkg.sv
rtl/oftc_ram.sv
rtl/oldest_first_slot_cache_tags.sv
tb/sv/tb_oldest_first_slot_cache_tags.sv
